>>> hdl/pln_pkg.sv
// Package for the path lexical normaliser: transaction structs, command,
// status and dot-tracking codes, and the default store size.
// No dependencies.
package pln_pkg;

   // Default number of bytes in the cleaned path store
   localparam int MAX_LEN_DEF = 4096;

   // Field widths fixed by the interface
   localparam int CMD_W    = 1;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 12;
   localparam int LENGTH_W = 13;
   localparam int STATUS_W = 2;

   // Commands
   localparam logic [CMD_W-1:0] CMD_BYTE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RELATIVE = 2'd3;

   // Dot tracking of the open component
   localparam logic [1:0] DOT_NONE = 2'd0;
   localparam logic [1:0] DOT_ONE  = 2'd1;
   localparam logic [1:0] DOT_TWO  = 2'd2;

   // Characters
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [BYTE_W-1:0]  path_byte;
      logic               last_byte;
      logic [INDEX_W-1:0] read_index;
   } pln_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [LENGTH_W-1:0] clean_length;
      logic                path_done;
      logic [STATUS_W-1:0] status;
   } pln_rsp_type;

endpackage

>>> hdl/path_lexical_normalizer_unit.sv
// Path lexical normaliser: cleans an absolute path byte by byte into a byte
// store and serves reads from it. Depends on pln_pkg.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    pln_req_type (byte or read command)
//   rsp_      out        rsp_valid/rsp_ready    pln_rsp_type (one per transaction)
//
// One transaction is accepted per cycle while req_ready is high; its response
// passes through stage one (the byte-store read registers) and the output register.
// A ".." pops the component-start stack directly: the top entry lives in a
// register and the entry below it is pre-read from the stack memory each cycle.
// The byte store is split into even and odd banks so a separator and a
// character land in the same cycle. Memories are not cleared after reset;
// reads beyond the committed length return zero. Stalls on rsp_ready hold
// the pipeline and drop req_ready only once both stages are full.
module path_lexical_normalizer_unit
   import pln_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pln_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pln_rsp_type rsp_data
);

   localparam int AW        = $clog2(MAX_LEN);        // store address
   localparam int PW        = $clog2(MAX_LEN + 1);    // lengths up to MAX_LEN
   localparam int EW        = PW + 1;                 // sums of lengths
   localparam int BW        = AW - 1;                 // bank address
   localparam int BANK_D    = (MAX_LEN + 1) / 2;
   localparam int STACK_MAX = MAX_LEN / 2;
   localparam int SW        = $clog2(STACK_MAX);
   localparam int DW        = $clog2(STACK_MAX + 1);
   localparam int IW        = (PW > INDEX_W) ? PW : INDEX_W;

   localparam logic [EW-1:0] MAX_E   = EW'(MAX_LEN);
   localparam logic [PW-1:0] MAX_P   = PW'(MAX_LEN);
   localparam logic [DW-1:0] STK_MAX = DW'(STACK_MAX);

   // Memories
   logic [BYTE_W-1:0] even_mem [BANK_D];
   logic [BYTE_W-1:0] odd_mem  [BANK_D];
   logic [PW-1:0]     stk_mem  [STACK_MAX];

   // Path state
   logic [PW-1:0] wp_ff, wp_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [PW-1:0] top_ff, top_in;
   logic [PW-1:0] len_ff, len_in;
   logic [1:0]    dot_ff, dot_in;
   logic          sa_ff, sa_in;
   logic          started_ff, started_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic          halted_ff, halted_in;
   logic          fin_ff, fin_in;

   // Pipeline
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_hit_ff, s1_bank_ff;
   logic [LENGTH_W-1:0] s1_len_ff;
   logic          s1_done_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   pln_rsp_type   rsp_data_ff;
   logic [BYTE_W-1:0] even_rd_ff, odd_rd_ff;
   logic [PW-1:0] stk_rd_ff;

   // Working signals
   logic          req_fire, s1_move, is_byte, is_read, rd_hit;
   logic          sa_add, is_char, do_close, len_c_zero;
   logic [PW-1:0] len_c;
   logic [1:0]    dot_c;
   logic          sa_c;
   logic [EW-1:0] pos_e, end_e;
   logic          sl_we, by_we, stk_we;
   logic [AW-1:0] sl_addr, by_addr, rd_addr;
   logic [BYTE_W-1:0] by_data;
   logic          ev_we, od_we;
   logic [BW-1:0] ev_addr, od_addr;
   logic [BYTE_W-1:0] ev_data, od_data;
   logic [DW-1:0] depth_m2;
   logic [BYTE_W-1:0] s1_byte;

   // Handshake: advance stage one when the output register frees up
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_byte   = req_fire && (req_data.cmd == CMD_BYTE);
   assign is_read   = req_fire && (req_data.cmd == CMD_READ);
   assign rd_hit    = IW'(req_data.read_index) < IW'(wp_ff);
   assign rd_addr   = AW'(req_data.read_index);

   // Positions of the byte about to be added and of the end of the component
   assign sa_add  = (len_ff == '0) ? (wp_ff > PW'(1)) : sa_ff;
   assign is_char = (req_data.path_byte != CH_NUL) && (req_data.path_byte != CH_SLASH);
   assign pos_e   = EW'(wp_ff) + EW'(sa_add) + EW'(len_ff);
   assign end_e   = (is_char && (len_ff != MAX_P)) ? pos_e + EW'(1) : pos_e;

   // Next path state
   always_comb begin
      wp_in      = wp_ff;
      depth_in   = depth_ff;
      top_in     = top_ff;
      len_in     = len_ff;
      dot_in     = dot_ff;
      sa_in      = sa_ff;
      started_in = started_ff;
      err_in     = err_ff;
      halted_in  = halted_ff;
      fin_in     = fin_ff;
      len_c      = len_ff;
      dot_c      = dot_ff;
      sa_c       = sa_ff;
      do_close   = 1'b0;
      sl_we      = 1'b0;
      sl_addr    = wp_ff[AW-1:0];
      by_we      = 1'b0;
      by_addr    = pos_e[AW-1:0];
      by_data    = req_data.path_byte;
      stk_we     = 1'b0;
      if (is_byte) begin
         if (!started_ff) begin
            // open a new path
            wp_in      = '0;
            depth_in   = '0;
            len_in     = '0;
            dot_in     = DOT_NONE;
            sa_in      = 1'b0;
            err_in     = ST_OK;
            halted_in  = 1'b0;
            fin_in     = 1'b0;
            started_in = 1'b1;
            if (req_data.path_byte == CH_NUL) begin
               err_in    = ST_EMPTY;
               halted_in = 1'b1;
            end else if (req_data.path_byte != CH_SLASH) begin
               err_in    = ST_RELATIVE;
               halted_in = 1'b1;
            end else begin
               by_we   = 1'b1;
               by_addr = '0;
               by_data = CH_SLASH;
               wp_in   = PW'(1);
            end
         end else if (!halted_ff) begin
            if (req_data.path_byte == CH_NUL) begin
               do_close  = 1'b1;
               halted_in = 1'b1;
            end else if (req_data.path_byte == CH_SLASH) begin
               do_close = 1'b1;
            end else begin
               // append a character, with a separator ahead of a fresh component
               sa_c = sa_add;
               if (len_ff == '0) begin
                  sl_we = sa_add && (wp_ff < MAX_P);
               end
               by_we = pos_e < MAX_E;
               if (req_data.path_byte == CH_DOT && len_ff == '0) begin
                  dot_c = DOT_ONE;
               end else if (req_data.path_byte == CH_DOT && len_ff == PW'(1) &&
                            dot_ff == DOT_ONE) begin
                  dot_c = DOT_TWO;
               end else begin
                  dot_c = DOT_NONE;
               end
               if (len_ff != MAX_P) begin
                  len_c = len_ff + PW'(1);
               end
               do_close = req_data.last_byte;
            end
            len_in = len_c;
            dot_in = dot_c;
            sa_in  = sa_c;
            if (do_close) begin
               // close the open component
               if (len_c == PW'(1) && dot_c == DOT_ONE) begin
                  // drop "."
               end else if (len_c == PW'(2) && dot_c == DOT_TWO) begin
                  if (depth_ff != '0) begin
                     depth_in = depth_ff - DW'(1);
                     wp_in    = top_ff;
                     top_in   = stk_rd_ff;
                  end
               end else if (len_c == '0) begin
                  // nothing open
               end else if (end_e >= MAX_E) begin
                  err_in    = ST_TOO_LONG;
                  halted_in = 1'b1;
               end else begin
                  if (depth_ff < STK_MAX) begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + DW'(1);
                     top_in   = wp_ff;
                  end
                  wp_in = PW'(end_e);
               end
               len_in = '0;
               dot_in = DOT_NONE;
               sa_in  = 1'b0;
            end
         end
         if (req_data.last_byte) begin
            fin_in     = 1'b1;
            started_in = 1'b0;
         end
      end
   end

   assign len_c_zero = (len_c == '0);

   // Route the two store writes to the even and odd banks
   always_comb begin
      if (sl_we && !sl_addr[0]) begin
         ev_we   = 1'b1;
         ev_addr = sl_addr[AW-1:1];
         ev_data = CH_SLASH;
      end else begin
         ev_we   = by_we && !by_addr[0];
         ev_addr = by_addr[AW-1:1];
         ev_data = by_data;
      end
      if (sl_we && sl_addr[0]) begin
         od_we   = 1'b1;
         od_addr = sl_addr[AW-1:1];
         od_data = CH_SLASH;
      end else begin
         od_we   = by_we && by_addr[0];
         od_addr = by_addr[AW-1:1];
         od_data = by_data;
      end
   end

   // Byte store banks
   always_ff @(posedge clock) begin
      if (ev_we) begin
         even_mem[ev_addr] <= ev_data;
      end
      if (is_read) begin
         even_rd_ff <= even_mem[rd_addr[AW-1:1]];
      end
   end

   always_ff @(posedge clock) begin
      if (od_we) begin
         odd_mem[od_addr] <= od_data;
      end
      if (is_read) begin
         odd_rd_ff <= odd_mem[rd_addr[AW-1:1]];
      end
   end

   // Component-start stack: pre-read the entry below the new top every cycle
   assign depth_m2 = depth_in - DW'(2);

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[depth_ff[SW-1:0]] <= wp_ff;
      end
      stk_rd_ff <= stk_mem[depth_m2[SW-1:0]];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         depth_ff     <= '0;
         len_ff       <= '0;
         dot_ff       <= DOT_NONE;
         sa_ff        <= 1'b0;
         started_ff   <= 1'b0;
         err_ff       <= ST_OK;
         halted_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         depth_ff     <= depth_in;
         len_ff       <= len_in;
         dot_ff       <= dot_in;
         sa_ff        <= sa_in;
         started_ff   <= started_in;
         err_ff       <= err_in;
         halted_ff    <= halted_in;
         fin_ff       <= fin_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   // Pick the bank that holds the read byte
   assign s1_byte = !s1_hit_ff ? '0 : (s1_bank_ff ? odd_rd_ff : even_rd_ff);

   // Payload registers
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (req_fire) begin
         s1_hit_ff    <= is_read && rd_hit;
         s1_bank_ff   <= rd_addr[0];
         s1_len_ff    <= LENGTH_W'(wp_in);
         s1_done_ff   <= fin_in;
         s1_status_ff <= err_in;
      end
      if (s1_move) begin
         rsp_data_ff.out_byte     <= s1_byte;
         rsp_data_ff.clean_length <= s1_len_ff;
         rsp_data_ff.path_done    <= s1_done_ff;
         rsp_data_ff.status       <= s1_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      (sl_we && by_we) |-> (sl_addr[0] != by_addr[0]))
      else $error("separator and character writes hit the same bank");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff < MAX_P)
      else $error("committed length reached the store size");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |-> !req_ready)
      else $error("transaction accepted while stage one is stalled");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !started_ff)
      else $error("path marked done while still open");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (is_byte && started_ff && !halted_ff && do_close && !len_c_zero) |=>
      (len_ff == '0))
      else $error("component length not cleared on close");

endmodule
